>>> rtl/core/dvrt_pkg.sv
// Package for the distance-vector route table: widths, status codes, config indexes.
// No dependencies.
`timescale 1ns / 1ps
package dvrt_pkg;
  localparam int TableDepth = 32;
  localparam int IfaceCount = 16;
  localparam logic [15:0] ResetTimeout = 16'd20;
  localparam logic [7:0] ResetInfinity = 8'd16;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_ADDED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;
  localparam logic [2:0] ST_STATUS = 3'd6;

  localparam logic [1:0] KIND_ROUTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_IFACE = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_INFINITY = 1'b1;

  // Result of one table walk.
  typedef struct packed {
    logic [2:0] status;
    logic       changed;
    logic [5:0] touched;
  } result_t;
endpackage

>>> rtl/core/dvrt_entry_mem.sv
// Route entry storage: one write port, one registered read port, valid bits in flops.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module dvrt_entry_mem #(
  parameter int DEPTH = 32,
  parameter int AW = 5,
  parameter int DW = 124
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  output logic          rd_valid,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  // Memory array, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid <= valid_r[rd_addr];
    end
  end
endmodule

>>> rtl/core/distance_vector_route_table_top.sv
// Distance-vector route table top: sequencer walking the entry memory one entry a pass.
// Depends on dvrt_pkg and dvrt_entry_mem.
// A walked route entry reads and decides/writes each table entry in turn, then appends;
// a tick or status walks the table without the append, and ignored items go straight to
// the result. No new item is taken until the result is out (busy meanwhile); no result stalls.
// Reset: valid bits, clock, registers to defaults; no clearing pass.
`timescale 1ns / 1ps
module distance_vector_route_table_top #(
  parameter int TABLE_DEPTH = dvrt_pkg::TableDepth,
  parameter int IFACE_COUNT = dvrt_pkg::IfaceCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_address_family,
  input  logic [31:0] in_route_address,
  input  logic [31:0] in_route_mask,
  input  logic [31:0] in_route_next_hop,
  input  logic [7:0]  in_route_metric,
  input  logic [31:0] in_sender_address,
  input  logic [3:0]  in_iface_index,
  input  logic [31:0] in_iface_address,
  input  logic        in_iface_up,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_table_changed,
  output logic [5:0]  out_entries_touched
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int DW = 124;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_APPEND, S_DONE} state_t;

  state_t state_r;
  logic [CW-1:0] idx_r;
  logic [15:0] timeout_r, clock_r;
  logic [7:0] inf_r, metric_r;
  logic [1:0] kind_r;
  logic [31:0] addr_r, mask_r, sender_r;
  logic [3:0] ifc_r;
  logic up_r, found_r, free_found_r;
  logic [AW-1:0] free_r;
  dvrt_pkg::result_t res_r;

  logic [DW-1:0] rd_data, wr_data;
  logic rd_valid, wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] e_prefix, e_mask, e_gw;
  logic [3:0] e_ifc;
  logic [7:0] e_metric;
  logic [15:0] e_stamp;

  assign {e_prefix, e_mask, e_gw, e_ifc, e_metric, e_stamp} = rd_data;
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  dvrt_entry_mem #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(DW)) u_mem (
    .clk(clk), .rst_n(rst_n), .rd_addr(idx_r[AW-1:0]), .rd_data(rd_data),
    .rd_valid(rd_valid), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // Per-entry decision on the shared compare unit.
  logic match, stale;
  logic [15:0] age;
  always_comb begin
    match = rd_valid && ((e_prefix & e_mask) == (addr_r & mask_r));
    age = clock_r - e_stamp;
    stale = rd_valid && (age >= timeout_r) && (e_metric != inf_r);
    wr_en = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data;
    if (state_r == S_EVAL) begin
      unique case (kind_r)
        dvrt_pkg::KIND_ROUTE: begin
          if (match && !found_r) begin
            if (e_gw == sender_r) begin
              wr_en = 1'b1;
              wr_data = {e_prefix, e_mask, e_gw, e_ifc, metric_r, clock_r};
            end else if (metric_r < e_metric) begin
              wr_en = 1'b1;
              wr_data = {e_prefix, mask_r, sender_r, ifc_r, metric_r, clock_r};
            end
          end
        end
        dvrt_pkg::KIND_TICK: begin
          if (stale) begin
            wr_en = 1'b1;
            wr_data = {e_prefix, e_mask, e_gw, e_ifc, inf_r, e_stamp};
          end
        end
        default: begin
          if (!up_r && rd_valid && e_ifc == ifc_r && e_metric != inf_r) begin
            wr_en = 1'b1;
            wr_data = {e_prefix, e_mask, e_gw, e_ifc, inf_r, e_stamp};
          end else if (up_r && match) begin
            wr_en = 1'b1;
            wr_data = {e_prefix, e_mask, 32'd0, ifc_r, 8'd0, clock_r};
          end
        end
      endcase
    end else if (state_r == S_APPEND && free_found_r && !found_r) begin
      wr_en = 1'b1;
      wr_addr = free_r;
      wr_data = {addr_r, mask_r, sender_r, ifc_r, metric_r, clock_r};
    end
  end

  // Sequencer, configuration and result registers.
  logic [8:0] m_inc;
  assign m_inc = {1'b0, in_route_metric} + 9'd1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      timeout_r <= dvrt_pkg::ResetTimeout;
      inf_r <= dvrt_pkg::ResetInfinity;
      clock_r <= '0;
      out_strobe <= 1'b0;
      idx_r <= '0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == dvrt_pkg::CFG_TIMEOUT) timeout_r <= cfg_data;
            else inf_r <= cfg_data[7:0];
          end
          if (start) begin
            kind_r <= in_kind;
            addr_r <= in_route_address;
            mask_r <= in_route_mask;
            sender_r <= in_sender_address;
            ifc_r <= in_iface_index;
            up_r <= in_iface_up;
            metric_r <= (m_inc > {1'b0, inf_r}) ? inf_r : m_inc[7:0];
            found_r <= 1'b0;
            free_found_r <= 1'b0;
            free_r <= '0;
            idx_r <= '0;
            res_r <= '0;
            if (in_kind == dvrt_pkg::KIND_TICK) begin
              clock_r <= clock_r + 16'd1;
              res_r.status <= dvrt_pkg::ST_TICK;
              state_r <= S_READ;
            end else if (in_kind == dvrt_pkg::KIND_IFACE
                         && 32'(in_iface_index) < IFACE_COUNT) begin
              res_r.status <= dvrt_pkg::ST_STATUS;
              state_r <= S_READ;
            end else if (in_kind == dvrt_pkg::KIND_ROUTE && in_address_family != 16'd0
                         && in_route_next_hop != in_iface_address
                         && 32'(in_iface_index) < IFACE_COUNT) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          if (wr_en) res_r.touched <= res_r.touched + 6'd1;
          if (kind_r == dvrt_pkg::KIND_ROUTE) begin
            if (match && !found_r) begin
              found_r <= 1'b1;
              if (e_gw == sender_r) res_r.status <= dvrt_pkg::ST_REFRESHED;
              else if (metric_r < e_metric) begin
                res_r.status <= dvrt_pkg::ST_REPLACED;
                res_r.changed <= 1'b1;
              end
            end
            if (!rd_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_r <= idx_r[AW-1:0];
            end
          end
          if (idx_r == CW'(TABLE_DEPTH - 1)) begin
            state_r <= (kind_r == dvrt_pkg::KIND_ROUTE) ? S_APPEND : S_DONE;
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_READ;
          end
        end
        S_APPEND: begin
          if (!found_r) begin
            if (free_found_r) begin
              res_r <= '{status: dvrt_pkg::ST_ADDED, changed: 1'b1, touched: 6'd1};
            end else begin
              res_r.status <= dvrt_pkg::ST_FULL;
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_status <= res_r.status;
          out_table_changed <= res_r.changed;
          out_entries_touched <= res_r.touched;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result only leaves the done state.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_DONE) else $error("strobe outside done");
  // Only route items change the table flag, and then with exactly one entry touched.
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_table_changed |-> out_entries_touched == 6'd1)
    else $error("changed without one touch");
  // No write occurs while idle.
  a_idle_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !wr_en) else $error("write while idle");
endmodule
